// File: design/drsi_pkg.sv
// Shared constants and types for the document number range set iterator.
`timescale 1ns / 1ps

package drsi_pkg;

    localparam int MAX_RANGES = 64;
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam int KW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int E1 = (MAX_RANGES > 1) ? 1 : 0;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_NEXT   = 2'd1;
    localparam logic [1:0] MODE_SKIP   = 2'd2;

    typedef struct packed {
        logic [31:0] low;
        logic [31:0] high;
    } range_t;

endpackage

// File: design/docid_range_set_iterator.sv
// Top level: range ring of cells and the controller that walks it for each item.
// Each item walks one full rotation of the cell ring, one slot past the
// controller per cycle, and then shows its result in the done cycle.
// A new item can be started in the done cycle; no item is taken while the
// walk is busy. The receiver cannot stall; results show for one cycle.
// Reset clears the counts, the cursor and the overflow flag; slot contents are not reset.
`timescale 1ns / 1ps

module docid_range_set_iterator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [31:0] doc_id,
    output logic        done,
    output logic [31:0] cursor_value,
    output logic        at_end,
    output logic        table_full,
    output logic [6:0]  range_count
);
    import drsi_pkg::*;

    typedef enum logic {ST_IDLE, ST_WALK} state_t;
    typedef enum logic [2:0] {IM_SCAN, IM_PASS, IM_INS, IM_DROP, IM_EXTLOW, IM_NEWAT} ins_t;

    range_t cell_q [MAX_RANGES];
    range_t cell_d [MAX_RANGES];
    range_t ring_in;
    logic   walking;

    state_t      state_reg, state_next;
    ins_t        im_reg, im_next;
    logic [KW-1:0] step_reg, step_next;
    logic [CW-1:0] used_reg, used_next;
    logic [CW-1:0] slot_reg, slot_next;
    logic [31:0] num_reg, num_next;
    logic        started_reg, started_next;
    logic        ovf_reg, ovf_next;
    logic [31:0] arg_reg, arg_next;
    range_t      hold_reg, hold_next;
    logic        nx_reg, nx_next;
    logic        search_reg, search_next;
    logic        inc_reg, inc_next;
    logic        dec_reg, dec_next;
    logic        done_reg, done_next;

    range_t      e0, e1;
    logic [CW-1:0] k_ext;
    logic        valid0, valid1, last, full, is_i, plus_next, at_end_w;
    logic [CW-1:0] slot_w;
    logic [31:0] num_w;

    assign walking = (state_reg == ST_WALK);

    genvar j;
    generate
        for (j = 0; j < MAX_RANGES; j++)
        begin : g_cell
            if (j == MAX_RANGES - 1)
            begin : g_tail
                assign cell_d[j] = ring_in;
            end
            else
            begin : g_body
                assign cell_d[j] = cell_q[j + 1];
            end
            drsi_cell u_cell (
                .clk   (clk),
                .shift (walking),
                .d     (cell_d[j]),
                .q     (cell_q[j])
            );
        end
    endgenerate

    assign e0     = cell_q[0];
    assign e1     = cell_q[E1];
    assign k_ext  = CW'(step_reg);
    assign valid0 = k_ext < used_reg;
    assign valid1 = (k_ext + CW'(1)) < used_reg;
    assign last   = step_reg == KW'(MAX_RANGES - 1);
    assign full   = used_reg == CW'(MAX_RANGES);
    assign is_i   = !(valid1 && (e1.low <= arg_reg));
    assign plus_next = valid1 && (arg_reg != 32'hFFFF_FFFF) && (e1.low == arg_reg + 32'd1);

    always_comb
    begin
        state_next   = state_reg;
        im_next      = im_reg;
        step_next    = step_reg;
        used_next    = used_reg;
        slot_next    = slot_reg;
        num_next     = num_reg;
        started_next = started_reg;
        ovf_next     = ovf_reg;
        arg_next     = arg_reg;
        hold_next    = hold_reg;
        nx_next      = nx_reg;
        search_next  = search_reg;
        inc_next     = inc_reg;
        dec_next     = dec_reg;
        done_next    = 1'b0;
        ring_in      = e0;
        slot_w       = slot_reg;
        num_w        = num_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next  = ST_WALK;
                    step_next   = '0;
                    arg_next    = doc_id;
                    im_next     = IM_PASS;
                    nx_next     = 1'b0;
                    search_next = 1'b0;
                    inc_next    = 1'b0;
                    dec_next    = 1'b0;
                    if (!started_reg)
                    begin
                        slot_w = '0;
                        num_w  = (used_reg != '0) ? e0.low : 32'd0;
                    end
                    case (mode)
                        MODE_INSERT:
                        begin
                            im_next      = IM_SCAN;
                            started_next = 1'b0;
                            slot_next    = '0;
                            num_next     = '0;
                        end
                        MODE_NEXT:
                        begin
                            if (!started_reg)
                            begin
                                started_next = 1'b1;
                                slot_next    = slot_w;
                                num_next     = num_w;
                            end
                            else if (slot_reg < used_reg)
                            begin
                                nx_next = 1'b1;
                            end
                        end
                        MODE_SKIP:
                        begin
                            started_next = 1'b1;
                            slot_next    = slot_w;
                            num_next     = num_w;
                            search_next  = (slot_w < used_reg) && (doc_id > num_w);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                step_next = step_reg + KW'(1);
                case (im_reg)
                    IM_SCAN:
                    begin
                        im_next = IM_PASS;
                        if ((step_reg == '0) && (!valid0 || (arg_reg < e0.low)))
                        begin
                            if (valid0 && (arg_reg + 32'd1 == e0.low))
                            begin
                                ring_in = '{low: arg_reg, high: e0.high};
                            end
                            else if (full)
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                ring_in   = '{low: arg_reg, high: arg_reg};
                                hold_next = e0;
                                im_next   = IM_INS;
                                inc_next  = 1'b1;
                            end
                        end
                        else if (!is_i)
                        begin
                            im_next = IM_SCAN;
                        end
                        else if (arg_reg <= e0.high)
                        begin
                            im_next = IM_PASS;
                        end
                        else if (arg_reg == e0.high + 32'd1)
                        begin
                            if (plus_next)
                            begin
                                ring_in  = '{low: e0.low, high: e1.high};
                                im_next  = IM_DROP;
                                dec_next = 1'b1;
                            end
                            else
                            begin
                                ring_in = '{low: e0.low, high: arg_reg};
                            end
                        end
                        else if (plus_next)
                        begin
                            im_next = IM_EXTLOW;
                        end
                        else if (full)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            im_next  = IM_NEWAT;
                            inc_next = 1'b1;
                        end
                    end
                    IM_INS:
                    begin
                        ring_in   = hold_reg;
                        hold_next = e0;
                    end
                    IM_DROP:
                    begin
                        ring_in = e1;
                    end
                    IM_EXTLOW:
                    begin
                        ring_in = '{low: arg_reg, high: e0.high};
                        im_next = IM_PASS;
                    end
                    IM_NEWAT:
                    begin
                        ring_in   = '{low: arg_reg, high: arg_reg};
                        hold_next = e0;
                        im_next   = IM_INS;
                    end
                    default:
                    begin
                        ring_in = e0;
                    end
                endcase
                if (nx_reg && (k_ext == slot_reg))
                begin
                    nx_next = 1'b0;
                    if (num_reg < e0.high)
                    begin
                        num_next = num_reg + 32'd1;
                    end
                    else
                    begin
                        slot_next = slot_reg + CW'(1);
                        num_next  = valid1 ? e1.low : 32'd0;
                    end
                end
                if (search_reg && (k_ext >= slot_reg))
                begin
                    if (valid0 && (e0.high < arg_reg))
                    begin
                        if (last)
                        begin
                            slot_next   = CW'(MAX_RANGES);
                            num_next    = 32'd0;
                            search_next = 1'b0;
                        end
                    end
                    else
                    begin
                        slot_next   = k_ext;
                        num_next    = valid0 ? ((e0.low > arg_reg) ? e0.low : arg_reg) : 32'd0;
                        search_next = 1'b0;
                    end
                end
                if (last)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    used_next  = used_reg + CW'(inc_next) - CW'(dec_next);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            im_reg      <= IM_PASS;
            step_reg    <= '0;
            used_reg    <= '0;
            slot_reg    <= '0;
            num_reg     <= '0;
            started_reg <= 1'b0;
            ovf_reg     <= 1'b0;
            nx_reg      <= 1'b0;
            search_reg  <= 1'b0;
            inc_reg     <= 1'b0;
            dec_reg     <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            im_reg      <= im_next;
            step_reg    <= step_next;
            used_reg    <= used_next;
            slot_reg    <= slot_next;
            num_reg     <= num_next;
            started_reg <= started_next;
            ovf_reg     <= ovf_next;
            nx_reg      <= nx_next;
            search_reg  <= search_next;
            inc_reg     <= inc_next;
            dec_reg     <= dec_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        arg_reg  <= arg_next;
        hold_reg <= hold_next;
    end

    assign at_end_w     = started_reg && (slot_reg >= used_reg);
    assign busy         = walking;
    assign done         = done_reg;
    assign cursor_value = at_end_w ? 32'd0 : num_reg;
    assign at_end       = at_end_w;
    assign table_full   = ovf_reg;
    assign range_count  = 7'(used_reg);

endmodule

// File: design/drsi_cell.sv
// One slot of the range ring; it takes its neighbor's range on every shift.
`timescale 1ns / 1ps

module drsi_cell (
    input  logic            clk,
    input  logic            shift,
    input  drsi_pkg::range_t d,
    output drsi_pkg::range_t q
);
    import drsi_pkg::*;

    range_t q_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule

// File: design/drsi_checker.sv
// Port-level checks for the range set iterator, bound to the top level.
`timescale 1ns / 1ps

module drsi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [31:0] cursor_value,
    input logic        at_end
);
    import drsi_pkg::*;

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not make the block busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two results in consecutive cycles");

    a_fell_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("walk ended without a result");

    a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && at_end) |-> (cursor_value == 32'd0))
        else $error("cursor value not zero at end");

endmodule

bind docid_range_set_iterator drsi_checker u_drsi_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .cursor_value (cursor_value),
    .at_end       (at_end)
);
